// ===== src/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types, phase codes and the sample rate table for the sample header
// table parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OFFS_W   = 30;
    localparam int unsigned SKIP_W   = 23;
    localparam int unsigned PHASE_W  = 4;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_MODE   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_OFFSET = 4'd1;
    localparam logic [PHASE_W-1:0] PH_UNKN   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_XHDR   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_XTYPE  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CHAN   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_FREQ   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_LOOPS  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_LOOPE  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_CRC    = 4'd9;
    localparam logic [PHASE_W-1:0] PH_SKIP   = 4'd10;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_FREQ = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SEEK = 2'd3;

    // extra header types
    localparam logic [BYTE_W-1:0] XT_CHANNELS = 8'h02;
    localparam logic [BYTE_W-1:0] XT_FREQ     = 8'h04;
    localparam logic [BYTE_W-1:0] XT_LOOP     = 8'h06;
    localparam logic [BYTE_W-1:0] XT_CRC      = 8'h16;

    // required payload lengths (the crc length is a minimum)
    localparam logic [SKIP_W-1:0] LEN_CHANNELS = 23'd1;
    localparam logic [SKIP_W-1:0] LEN_FREQ     = 23'd4;
    localparam logic [SKIP_W-1:0] LEN_LOOP     = 23'd8;
    localparam logic [SKIP_W-1:0] LEN_CRC      = 23'd4;

    typedef struct packed {
        logic [CHAN_W-1:0] channels;
        logic [WORD_W-1:0] frequency;
        logic [OFFS_W-1:0] data_offset;
        logic [WORD_W-1:0] unknown_word;
        logic [WORD_W-1:0] loop_begin;
        logic [WORD_W-1:0] loop_finish;
        logic              has_loop;
        logic [WORD_W-1:0] stream_crc;
        logic              has_crc;
    } t_hdr;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_hdr                hdr;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_result_beat;

    function automatic logic [WORD_W-1:0] rate_lookup(input logic [3:0] code);
        logic [WORD_W-1:0] rate;
        case (code)
            4'd1:    rate = 32'd8000;
            4'd2:    rate = 32'd11000;
            4'd3:    rate = 32'd11025;
            4'd4:    rate = 32'd16000;
            4'd5:    rate = 32'd22050;
            4'd6:    rate = 32'd24000;
            4'd7:    rate = 32'd32000;
            4'd8:    rate = 32'd44100;
            4'd9:    rate = 32'd48000;
            default: rate = '0;
        endcase
        return rate;
    endfunction

endpackage

// ===== src/asp_if.sv =====
// ----------------------------------------------------------------------------
// asp_in_if / asp_out_if
// Valid/ready channels for the header table bytes and the parsed headers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface asp_in_if;
    import asp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface asp_out_if;
    import asp_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHAN_W-1:0]   channels;
    logic [WORD_W-1:0]   frequency;
    logic [OFFS_W-1:0]   data_offset;
    logic [WORD_W-1:0]   unknown_word;
    logic [WORD_W-1:0]   loop_begin;
    logic [WORD_W-1:0]   loop_finish;
    logic                has_loop;
    logic [WORD_W-1:0]   stream_crc;
    logic                has_crc;

    modport source (
        output valid, output status, output channels, output frequency,
        output data_offset, output unknown_word, output loop_begin,
        output loop_finish, output has_loop, output stream_crc, output has_crc,
        input  ready
    );
    modport sink (
        input  valid, input status, input channels, input frequency,
        input  data_offset, input unknown_word, input loop_begin,
        input  loop_finish, input has_loop, input stream_crc, input has_crc,
        output ready
    );
endinterface

// ===== src/asp_parse_core.sv =====
// ----------------------------------------------------------------------------
// asp_parse_core
// Per-byte parser state update; produces at most one header result for each
// byte transfer, combinationally from the byte and the current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asp_parse_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_restart,
    output asp_pkg::t_result_beat o_beat
);
    import asp_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [1:0]         r_idx, n_idx;
    logic [SKIP_W-1:0]  r_skip, n_skip;
    logic [WORD_W-1:0]  r_asm, n_asm;
    logic               r_more, n_more;
    logic               r_halt, n_halt;
    t_hdr               r_hdr, n_hdr;

    logic [PHASE_W-1:0] c_phase;
    logic [1:0]         c_idx;
    logic [SKIP_W-1:0]  c_skip;
    logic [WORD_W-1:0]  c_asm;
    logic               c_more;
    logic               c_halt;
    logic [WORD_W-1:0]  asm_g;
    logic [SKIP_W-1:0]  skip_dec;
    logic               do_end;
    logic               emit;
    logic [STATUS_W-1:0] emit_status;

    always_comb begin
        // restart puts the parser back to its reset state before the byte
        c_phase = i_restart ? PH_MODE : r_phase;
        c_idx   = i_restart ? 2'd0 : r_idx;
        c_skip  = i_restart ? '0 : r_skip;
        c_asm   = i_restart ? '0 : r_asm;
        c_more  = i_restart ? 1'b0 : r_more;
        c_halt  = i_restart ? 1'b0 : r_halt;

        asm_g    = c_asm | (WORD_W'(i_data_byte) << {c_idx, 3'b000});
        skip_dec = c_skip - SKIP_W'(1);

        n_phase     = c_phase;
        n_idx       = c_idx;
        n_skip      = c_skip;
        n_asm       = c_asm;
        n_more      = c_more;
        n_halt      = c_halt;
        n_hdr       = r_hdr;
        do_end      = 1'b0;
        emit        = 1'b0;
        emit_status = ST_OK;

        if (!c_halt) begin
            case (c_phase)
                PH_MODE: begin
                    n_hdr             = '0;
                    n_more            = i_data_byte[0];
                    n_hdr.channels    = CHAN_W'(1) << i_data_byte[6:5];
                    n_hdr.data_offset = OFFS_W'(i_data_byte[7]);
                    n_idx             = 2'd0;
                    n_asm             = '0;
                    n_hdr.frequency   = rate_lookup(i_data_byte[4:1]);
                    if (n_hdr.frequency == '0) begin
                        n_hdr.data_offset = '0;
                        n_halt            = 1'b1;
                        emit              = 1'b1;
                        emit_status       = ST_BAD_FREQ;
                    end else begin
                        n_phase = PH_OFFSET;
                    end
                end
                PH_OFFSET: begin
                    n_asm = asm_g;
                    n_idx = c_idx + 2'd1;
                    if (c_idx == 2'd2) begin
                        n_hdr.data_offset = {asm_g[23:0], r_hdr.data_offset[0], 5'b00000};
                        n_asm             = '0;
                        n_idx             = 2'd0;
                        n_phase           = PH_UNKN;
                    end
                end
                PH_UNKN: begin
                    n_asm = asm_g;
                    n_idx = c_idx + 2'd1;
                    if (c_idx == 2'd3) begin
                        n_hdr.unknown_word = asm_g;
                        n_asm              = '0;
                        if (!c_more) begin
                            n_phase = PH_MODE;
                            emit    = 1'b1;
                        end else begin
                            n_phase = PH_XHDR;
                        end
                    end
                end
                PH_XHDR: begin
                    n_asm = asm_g;
                    n_idx = c_idx + 2'd1;
                    if (c_idx == 2'd2) begin
                        n_more  = asm_g[0];
                        n_skip  = asm_g[23:1];
                        n_asm   = '0;
                        n_idx   = 2'd0;
                        n_phase = PH_XTYPE;
                    end
                end
                PH_XTYPE: begin
                    n_asm = '0;
                    n_idx = 2'd0;
                    case (i_data_byte)
                        XT_CHANNELS: begin
                            if (c_skip != LEN_CHANNELS) begin
                                n_halt      = 1'b1;
                                emit        = 1'b1;
                                emit_status = ST_BAD_LEN;
                            end else begin
                                n_phase = PH_CHAN;
                            end
                        end
                        XT_FREQ: begin
                            if (c_skip != LEN_FREQ) begin
                                n_halt      = 1'b1;
                                emit        = 1'b1;
                                emit_status = ST_BAD_LEN;
                            end else begin
                                n_phase = PH_FREQ;
                            end
                        end
                        XT_LOOP: begin
                            if (c_skip != LEN_LOOP) begin
                                n_halt      = 1'b1;
                                emit        = 1'b1;
                                emit_status = ST_BAD_LEN;
                            end else begin
                                n_phase = PH_LOOPS;
                            end
                        end
                        XT_CRC: begin
                            if (c_skip < LEN_CRC) begin
                                n_halt      = 1'b1;
                                emit        = 1'b1;
                                emit_status = ST_BAD_LEN;
                            end else begin
                                n_skip  = c_skip - LEN_CRC;
                                n_phase = PH_CRC;
                            end
                        end
                        default: begin
                            if (c_skip == '0) begin
                                do_end = 1'b1;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    endcase
                end
                PH_CHAN: begin
                    n_hdr.channels = i_data_byte;
                    do_end         = 1'b1;
                end
                PH_FREQ: begin
                    n_asm = asm_g;
                    n_idx = c_idx + 2'd1;
                    if (c_idx == 2'd3) begin
                        n_hdr.frequency = asm_g;
                        do_end          = 1'b1;
                    end
                end
                PH_LOOPS: begin
                    n_asm = asm_g;
                    n_idx = c_idx + 2'd1;
                    if (c_idx == 2'd3) begin
                        n_hdr.loop_begin = asm_g;
                        n_asm            = '0;
                        n_phase          = PH_LOOPE;
                    end
                end
                PH_LOOPE: begin
                    n_asm = asm_g;
                    n_idx = c_idx + 2'd1;
                    if (c_idx == 2'd3) begin
                        n_hdr.loop_finish = asm_g;
                        n_hdr.has_loop    = 1'b1;
                        do_end            = 1'b1;
                    end
                end
                PH_CRC: begin
                    n_asm = asm_g;
                    n_idx = c_idx + 2'd1;
                    if (c_idx == 2'd3) begin
                        n_hdr.stream_crc = asm_g;
                        n_hdr.has_crc    = 1'b1;
                        n_asm            = '0;
                        if (c_skip[1:0] != 2'b00) begin
                            n_halt      = 1'b1;
                            emit        = 1'b1;
                            emit_status = ST_BAD_SEEK;
                        end else if (c_skip == '0) begin
                            do_end = 1'b1;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        do_end = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_MODE;
                end
            endcase

            // close one extra header: chain on, or finish the sample header
            if (do_end) begin
                n_idx = 2'd0;
                n_asm = '0;
                if (c_more) begin
                    n_phase = PH_XHDR;
                end else begin
                    n_phase = PH_MODE;
                    emit    = 1'b1;
                end
            end
        end

        o_beat.valid      = i_step && emit;
        o_beat.res.status = emit_status;
        o_beat.res.hdr    = n_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MODE;
            r_idx   <= 2'd0;
            r_skip  <= '0;
            r_asm   <= '0;
            r_more  <= 1'b0;
            r_halt  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_skip  <= n_skip;
            r_asm   <= n_asm;
            r_more  <= n_more;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_hdr <= n_hdr;
        end
    end

    // a halted parser stays silent until restart
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt && !i_restart) |-> !o_beat.valid)
        else $error("result produced while halted");

    // every error result halts the parser
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_beat.valid && o_beat.res.status != ST_OK) |=> r_halt)
        else $error("error result without halt");

    // a new header always starts on a word boundary
    a_mode_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MODE) |-> (r_idx == 2'd0))
        else $error("byte index not cleared at mode byte");

    // skip phase always has bytes left to drop
    a_skip_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP && !r_halt) |-> (r_skip != '0))
        else $error("skip phase with zero count");

endmodule

// ===== src/asp_out_skid.sv =====
// ----------------------------------------------------------------------------
// asp_out_skid
// Output register plus one skid entry, so the parser keeps taking bytes while
// a finished header waits at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asp_out_skid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  asp_pkg::t_result_beat i_beat,
    output logic                  o_ready,
    asp_out_if.source             o_out
);
    import asp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take    = r_out_valid && o_out.ready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_beat.valid;
            end else begin
                r_out_valid  <= i_beat.valid;
            end
        end else if (i_beat.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (i_beat.valid) begin
                    r_skid <= i_beat.res;
                end
            end else if (i_beat.valid) begin
                r_out <= i_beat.res;
            end
        end else if (i_beat.valid) begin
            r_skid <= i_beat.res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.channels     = r_out.hdr.channels;
    assign o_out.frequency    = r_out.hdr.frequency;
    assign o_out.data_offset  = r_out.hdr.data_offset;
    assign o_out.unknown_word = r_out.hdr.unknown_word;
    assign o_out.loop_begin   = r_out.hdr.loop_begin;
    assign o_out.loop_finish  = r_out.hdr.loop_finish;
    assign o_out.has_loop     = r_out.hdr.has_loop;
    assign o_out.stream_crc   = r_out.hdr.stream_crc;
    assign o_out.has_crc      = r_out.hdr.has_crc;

    // skid entry only fills behind an occupied output register
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output");

    // no result arrives while both entries are full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_beat.valid |-> !r_skid_valid)
        else $error("result pushed into full skid buffer");

    // a held result leaves the skid entry in place
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_out.ready) |=> r_skid_valid)
        else $error("skid entry lost while output stalled");

endmodule

// ===== src/audio_sample_header_parser.sv =====
// ----------------------------------------------------------------------------
// audio_sample_header_parser
// Parses a packed table of audio sample headers, one byte per transfer, and
// gives one result per finished header or on a format error.
// ----------------------------------------------------------------------------
// channel   dir   payload                                         role
// i_in      in    data_byte[8], restart[1]                        table bytes
// o_out     out   status, channels, frequency, data_offset,       header results
//                 unknown_word, loop_begin/finish, has_loop,
//                 stream_crc, has_crc
//
// one byte per cycle while i_in.ready is high; the parser state update is combinational logic
// a result enters the output stage in the cycle after the byte that completes it
// i_rst_n is synchronous; after reset the parser expects a mode byte
// a two-entry output stage (register plus skid) keeps bytes flowing while a
// result waits; i_in.ready drops only when both entries are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_sample_header_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    asp_in_if.sink    i_in,
    asp_out_if.source o_out
);
    import asp_pkg::*;

    t_result_beat beat;
    logic         step;
    logic         skid_ready;

    assign i_in.ready = skid_ready;
    assign step       = i_in.valid && skid_ready;

    asp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (i_in.data_byte),
        .i_restart   (i_in.restart),
        .o_beat      (beat)
    );

    asp_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .o_ready (skid_ready),
        .o_out   (o_out)
    );

endmodule

// ===== dv/tb_audio_sample_header_parser.sv =====
// ----------------------------------------------------------------------------
// tb_audio_sample_header_parser
// Feeds byte streams of packed sample header tables into the parser. Most are
// well-formed headers with random content and random extra header chains.
// The rest are bad rate codes, wrong extra lengths, bad seek remainders, cut
// tables and ignored bytes. A built-in parser mirror predicts every header
// result, and each result transfer is checked field by field. Both channels
// idle at random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_audio_sample_header_parser;
    import asp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES     = 200;
    localparam int unsigned ITEMS_PER_PHASE = 233;
    localparam int unsigned MAX_PRINTED     = 30;

    localparam logic [WORD_W-1:0] RATE_HZ [16] = '{
        32'd0, 32'd8000, 32'd11000, 32'd11025, 32'd16000, 32'd22050,
        32'd24000, 32'd32000, 32'd44100, 32'd48000,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              restart;
    } t_table_byte;

    logic clk;
    logic rst_n;

    asp_in_if  in_ch ();
    asp_out_if out_ch ();

    audio_sample_header_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_table_byte pending_bytes[$];
    t_result     expected_headers[$];
    t_table_byte next_byte;
    t_result     seen;

    int unsigned mismatches;
    int unsigned idle_cycles;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    logic        in_taken;
    logic        rx_hold;
    logic        hold_req;
    bit          need_restart;

    // parser mirror
    logic [PHASE_W-1:0] at_phase;
    logic [1:0]         at_pos;
    logic [SKIP_W-1:0]  skip_left;
    logic [WORD_W-1:0]  word_acc;
    logic               more_extras;
    logic               stopped;
    t_hdr               hdr_acc;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic check_header(input t_result want);
        check_field("status", seen.status, want.status);
        check_field("channels", seen.hdr.channels, want.hdr.channels);
        check_field("frequency", seen.hdr.frequency, want.hdr.frequency);
        check_field("data_offset", seen.hdr.data_offset, want.hdr.data_offset);
        check_field("unknown_word", seen.hdr.unknown_word, want.hdr.unknown_word);
        check_field("loop_begin", seen.hdr.loop_begin, want.hdr.loop_begin);
        check_field("loop_finish", seen.hdr.loop_finish, want.hdr.loop_finish);
        check_field("has_loop", seen.hdr.has_loop, want.hdr.has_loop);
        check_field("stream_crc", seen.hdr.stream_crc, want.hdr.stream_crc);
        check_field("has_crc", seen.hdr.has_crc, want.hdr.has_crc);
    endtask

    // ------------------------------------------------------------------
    // parser mirror
    // ------------------------------------------------------------------
    task automatic clear_parser();
        at_phase    = PH_MODE;
        at_pos      = '0;
        skip_left   = '0;
        word_acc    = '0;
        more_extras = 1'b0;
        stopped     = 1'b0;
        hdr_acc     = '0;
    endtask

    task automatic push_header(input logic [STATUS_W-1:0] st);
        t_result r;
        r.status = st;
        r.hdr    = hdr_acc;
        expected_headers.insert(expected_headers.size(), r);
    endtask

    task automatic raise_error(input logic [STATUS_W-1:0] st);
        stopped = 1'b1;
        push_header(st);
    endtask

    // little-endian assembly; true once the word has its n bytes (n = 0 means 4)
    function automatic bit take_byte(input logic [BYTE_W-1:0] b, input logic [1:0] n);
        word_acc = word_acc | ({24'd0, b} << (8 * at_pos));
        at_pos   = at_pos + 2'd1;
        return at_pos == n;
    endfunction

    task automatic finish_extra();
        at_pos   = '0;
        word_acc = '0;
        if (more_extras) begin
            at_phase = PH_XHDR;
        end else begin
            at_phase = PH_MODE;
            push_header(ST_OK);
        end
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic rs);
        logic [23:0] w;
        if (rs) clear_parser();
        if (!stopped) begin
            case (at_phase)
                PH_MODE: begin
                    hdr_acc             = '0;
                    more_extras         = b[0];
                    hdr_acc.channels    = 8'd1 << b[6:5];
                    hdr_acc.data_offset = {29'd0, b[7]};
                    at_pos              = '0;
                    word_acc            = '0;
                    hdr_acc.frequency   = RATE_HZ[b[4:1]];
                    if (hdr_acc.frequency == '0) begin
                        hdr_acc.data_offset = '0;
                        raise_error(ST_BAD_FREQ);
                    end else begin
                        at_phase = PH_OFFSET;
                    end
                end
                PH_OFFSET: begin
                    if (take_byte(b, 2'd3)) begin
                        w                   = word_acc[23:0];
                        hdr_acc.data_offset = {w, hdr_acc.data_offset[0], 5'd0};
                        word_acc            = '0;
                        at_pos              = '0;
                        at_phase            = PH_UNKN;
                    end
                end
                PH_UNKN: begin
                    if (take_byte(b, 2'd0)) begin
                        hdr_acc.unknown_word = word_acc;
                        if (!more_extras) begin
                            at_phase = PH_MODE;
                            push_header(ST_OK);
                        end else begin
                            word_acc = '0;
                            at_phase = PH_XHDR;
                        end
                    end
                end
                PH_XHDR: begin
                    if (take_byte(b, 2'd3)) begin
                        w           = word_acc[23:0];
                        more_extras = w[0];
                        skip_left   = w[23:1];
                        word_acc    = '0;
                        at_pos      = '0;
                        at_phase    = PH_XTYPE;
                    end
                end
                PH_XTYPE: begin
                    word_acc = '0;
                    at_pos   = '0;
                    case (b)
                        XT_CHANNELS: begin
                            if (skip_left != LEN_CHANNELS) raise_error(ST_BAD_LEN);
                            else at_phase = PH_CHAN;
                        end
                        XT_FREQ: begin
                            if (skip_left != LEN_FREQ) raise_error(ST_BAD_LEN);
                            else at_phase = PH_FREQ;
                        end
                        XT_LOOP: begin
                            if (skip_left != LEN_LOOP) raise_error(ST_BAD_LEN);
                            else at_phase = PH_LOOPS;
                        end
                        XT_CRC: begin
                            if (skip_left < LEN_CRC) begin
                                raise_error(ST_BAD_LEN);
                            end else begin
                                skip_left = skip_left - LEN_CRC;
                                at_phase  = PH_CRC;
                            end
                        end
                        default: begin
                            if (skip_left == '0) finish_extra();
                            else at_phase = PH_SKIP;
                        end
                    endcase
                end
                PH_CHAN: begin
                    hdr_acc.channels = b;
                    finish_extra();
                end
                PH_FREQ: begin
                    if (take_byte(b, 2'd0)) begin
                        hdr_acc.frequency = word_acc;
                        finish_extra();
                    end
                end
                PH_LOOPS: begin
                    if (take_byte(b, 2'd0)) begin
                        hdr_acc.loop_begin = word_acc;
                        word_acc           = '0;
                        at_phase           = PH_LOOPE;
                    end
                end
                PH_LOOPE: begin
                    if (take_byte(b, 2'd0)) begin
                        hdr_acc.loop_finish = word_acc;
                        hdr_acc.has_loop    = 1'b1;
                        finish_extra();
                    end
                end
                PH_CRC: begin
                    if (take_byte(b, 2'd0)) begin
                        hdr_acc.stream_crc = word_acc;
                        hdr_acc.has_crc    = 1'b1;
                        word_acc           = '0;
                        if (skip_left[1:0] != 2'd0) raise_error(ST_BAD_SEEK);
                        else if (skip_left == '0) finish_extra();
                        else at_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_left = skip_left - 23'd1;
                    if (skip_left == '0) finish_extra();
                end
                default: at_phase = PH_MODE;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // table byte generation
    // ------------------------------------------------------------------
    task automatic put(input logic [BYTE_W-1:0] b, input logic rs);
        t_table_byte t;
        t.value   = b;
        t.restart = rs;
        pending_bytes.insert(pending_bytes.size(), t);
    endtask

    task automatic put_word(input logic [WORD_W-1:0] w, input int unsigned n);
        for (int k = 0; k < n; k++) put(w[8*k +: 8], 1'b0);
    endtask

    task automatic put_bytes(input int unsigned n);
        repeat (n) put(8'($urandom), 1'b0);
    endtask

    task automatic put_xhdr(input logic [SKIP_W-1:0] len, input logic more);
        put_word({8'd0, len, more}, 3);
    endtask

    task automatic gen_entry();
        logic [BYTE_W-1:0] mode;
        logic [3:0]        code;
        logic [SKIP_W-1:0] len;
        logic [SKIP_W-1:0] need_len;
        logic [BYTE_W-1:0] xt;
        int unsigned       n_extra;
        int unsigned       kind;
        int unsigned       first;
        int unsigned       cut;
        bit                broken;
        bit                more;
        first  = pending_bytes.size();
        broken = 0;
        if ($urandom_range(99) < 8) begin
            code = ($urandom_range(1) == 1) ? 4'd0 : 4'($urandom_range(15, 10));
        end else begin
            code = 4'($urandom_range(9, 1));
        end
        mode      = 8'($urandom);
        mode[4:1] = code;
        mode[0]   = ($urandom_range(99) < 60);
        put(mode, need_restart || ($urandom_range(99) < 10));
        need_restart = 0;
        if (code == 4'd0 || code > 4'd9) begin
            broken = 1;
        end else begin
            put_word($urandom, 3);
            put_word($urandom, 4);
            if (mode[0]) begin
                n_extra = $urandom_range(4, 1);
                for (int i = 0; i < n_extra && !broken; i++) begin
                    more = (i + 1 < n_extra);
                    kind = $urandom_range(99);
                    if (kind < 14) begin
                        put_xhdr(LEN_CHANNELS, more);
                        put(XT_CHANNELS, 1'b0);
                        put_bytes(1);
                    end else if (kind < 28) begin
                        put_xhdr(LEN_FREQ, more);
                        put(XT_FREQ, 1'b0);
                        put_word($urandom, 4);
                    end else if (kind < 42) begin
                        put_xhdr(LEN_LOOP, more);
                        put(XT_LOOP, 1'b0);
                        put_word($urandom, 4);
                        put_word($urandom, 4);
                    end else if (kind < 62) begin
                        // crc plus seek data, sometimes with a ragged remainder
                        len = LEN_CRC + 23'(4 * $urandom_range(3));
                        if ($urandom_range(99) < 20) begin
                            len    = len + 23'($urandom_range(3, 1));
                            broken = 1;
                        end
                        put_xhdr(len, more);
                        put(XT_CRC, 1'b0);
                        put_word($urandom, 4);
                        if (!broken) put_bytes(len - LEN_CRC);
                    end else if (kind < 86) begin
                        do begin
                            xt = 8'($urandom);
                        end while (xt == XT_CHANNELS || xt == XT_FREQ ||
                                   xt == XT_LOOP || xt == XT_CRC);
                        len = 23'($urandom_range(6));
                        put_xhdr(len, more);
                        put(xt, 1'b0);
                        put_bytes(len);
                    end else begin
                        broken = 1;
                        case ($urandom_range(3))
                            0:       begin xt = XT_CHANNELS; need_len = LEN_CHANNELS; end
                            1:       begin xt = XT_FREQ;     need_len = LEN_FREQ;     end
                            2:       begin xt = XT_LOOP;     need_len = LEN_LOOP;     end
                            default: begin xt = XT_CRC;      need_len = LEN_CRC;      end
                        endcase
                        if (xt == XT_CRC) len = 23'($urandom_range(3));
                        else if ($urandom_range(1) == 1) len = 23'($urandom_range(12));
                        else len = 23'($urandom);
                        if (len == need_len) len = len ^ 23'd1;
                        put_xhdr(len, 1'($urandom_range(1)));
                        put(xt, 1'b0);
                    end
                end
            end
        end
        if (broken) begin
            // bytes after an error are dropped until the next restart
            put_bytes($urandom_range(3));
            need_restart = 1;
        end else if ($urandom_range(99) < 5 && pending_bytes.size() - first > 1) begin
            cut = $urandom_range(pending_bytes.size() - first - 1, 1);
            repeat (cut) void'(pending_bytes.pop_back());
            need_restart = 1;
        end
    endtask

    task automatic fill_random(input int unsigned n);
        while (pending_bytes.size() < n) gen_entry();
    endtask

    task automatic load_directed();
        // all-ones fields: channel field max (8 channels), top rate, full offset, no extras
        put(8'hF2, 1'b0);
        put_word(32'hFFFF_FFFF, 3);
        put_word(32'hFFFF_FFFF, 4);
        // rate code zero, then a byte that must be dropped
        put(8'h00, 1'b1);
        put(8'hFF, 1'b0);
        // restart into a header with a single crc extra and no seek data
        put(8'h03, 1'b1);
        put_word(32'h0, 3);
        put_word(32'h0, 4);
        put_xhdr(LEN_CRC, 1'b0);
        put(XT_CRC, 1'b0);
        put_word(32'hDEAD_BEEF, 4);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_headers.size() != 0 || in_ch.valid) begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // driver, receiver, monitor, watchdog
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_byte        = pending_bytes.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.data_byte <= next_byte.value;
                in_ch.restart   <= next_byte.restart;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off so the output stage fills and stalls the input
    initial begin
        rx_hold = 1'b0;
        wait (hold_req);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    always @(posedge clk) begin
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                seen.status           = out_ch.status;
                seen.hdr.channels     = out_ch.channels;
                seen.hdr.frequency    = out_ch.frequency;
                seen.hdr.data_offset  = out_ch.data_offset;
                seen.hdr.unknown_word = out_ch.unknown_word;
                seen.hdr.loop_begin   = out_ch.loop_begin;
                seen.hdr.loop_finish  = out_ch.loop_finish;
                seen.hdr.has_loop     = out_ch.has_loop;
                seen.hdr.stream_crc   = out_ch.stream_crc;
                seen.hdr.has_crc      = out_ch.has_crc;
                if (expected_headers.size() == 0) begin
                    report($sformatf("result with none expected, status %0d", seen.status));
                end else begin
                    check_header(expected_headers.pop_front());
                end
            end
            if (in_ch.valid && in_ch.ready) parse_byte(in_ch.data_byte, in_ch.restart);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.restart   = 1'b0;
        out_ch.ready    = 1'b0;
        in_taken        = 1'b0;
        hold_req        = 1'b0;
        mismatches      = 0;
        idle_cycles     = 0;
        need_restart    = 0;
        tx_idle_pct     = 11;
        rx_idle_pct     = 55;
        clear_parser();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_directed();
        fill_random(ITEMS_PER_PHASE);
        wait_drained();

        tx_idle_pct = 55;
        rx_idle_pct = 11;
        hold_req    = 1'b1;
        fill_random(ITEMS_PER_PHASE);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_random(ITEMS_PER_PHASE);
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/asp_pkg.sv
src/asp_if.sv
src/asp_parse_core.sv
src/asp_out_skid.sv
src/audio_sample_header_parser.sv
dv/tb_audio_sample_header_parser.sv
